// ===== rtl/trs_pkg.sv =====
// Package for the timed relay sequencer: sizes, command codes and transaction types.
`default_nettype none

package trs_pkg;

  // Sequence depth and number of relays driven
  localparam int MaxSteps   = 10;
  localparam int RelayCount = 7;

  // Step index and step count widths
  localparam int IdxW = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int CntW = $clog2(MaxSteps + 1);

  // Fixed field widths
  localparam int FuncW  = 3;
  localparam int ChanW  = 4;
  localparam int DelayW = 32;
  localparam int StepW  = 4;

  // Command codes
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_DEACT  = 3'd1,
    FUNC_SINGLE = 3'd2,
    FUNC_ENTRY  = 3'd3,
    FUNC_START  = 3'd4
  } trs_func_e;

  // Input transaction
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [ChanW-1:0]  channel;
    logic [DelayW-1:0] delay_ticks;
  } trs_in_t;

  // Result transaction
  typedef struct packed {
    logic [RelayCount-1:0] relay_on;
    logic                  alarm_active;
    logic                  cycle_running;
    logic [StepW-1:0]      current_step;
  } trs_out_t;

  // One-hot relay mask for a channel number; channels outside 1..RelayCount give zero
  function automatic logic [RelayCount-1:0] relay_mask(logic [ChanW-1:0] ch);
    logic [RelayCount-1:0] mask;
    mask = '0;
    for (int k = 0; k < RelayCount; k++) begin
      mask[k] = (32'(ch) == k + 1);
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trs_core.sv =====
// Sequencer state, step register file and per-command next-state logic.
`default_nettype none

module trs_core
  import trs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_en_i,
  input  wire trs_in_t  cmd_i,
  output trs_out_t      result_o
);

  // Control state
  logic [RelayCount-1:0] relay_q, relay_d;
  logic                  active_q, active_d;
  logic                  cycle_q, cycle_d;
  logic                  loading_q, loading_d;
  logic                  lit_q, lit_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [DelayW-1:0]     elapsed_q, elapsed_d;

  // Copy of the lit step's entry
  logic [ChanW-1:0]      cur_ch_q, cur_ch_d;
  logic [DelayW-1:0]     cur_dly_q, cur_dly_d;

  // Step register file, undefined until loaded
  logic [ChanW-1:0]      step_ch_q  [MaxSteps];
  logic [DelayW-1:0]     step_dly_q [MaxSteps];

  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  logic [IdxW-1:0]       rd_idx;
  logic [CntW-1:0]       idx_wrap;
  logic [CntW-1:0]       idx_inc;
  logic [CntW-1:0]       idx_next;
  logic [CntW-1:0]       cnt_eff;
  logic [DelayW-1:0]     elapsed_inc;
  logic                  tick_live;
  logic [IdxW+StepW-1:0] step_ext;

  // Index wrap and next-step index
  always_comb begin
    idx_wrap = (CntW'(idx_q) >= count_q) ? '0 : CntW'(idx_q);
    idx_inc  = idx_wrap + CntW'(1);
    idx_next = (idx_inc >= count_q) ? '0 : idx_inc;
    rd_idx   = lit_q ? idx_next[IdxW-1:0] : idx_wrap[IdxW-1:0];
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DelayW'(1);
    tick_live = active_q && cycle_q && !loading_q && (count_q != '0);
  end

  // Next state per command
  always_comb begin
    relay_d   = relay_q;
    active_d  = active_q;
    cycle_d   = cycle_q;
    loading_d = loading_q;
    lit_d     = lit_q;
    count_d   = count_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    cur_ch_d  = cur_ch_q;
    cur_dly_d = cur_dly_q;
    wr_en     = 1'b0;
    cnt_eff   = loading_q ? count_q : '0;
    wr_idx    = cnt_eff[IdxW-1:0];

    if (cmd_en_i) begin
      case (cmd_i.func)
        FUNC_TICK: begin
          if (tick_live) begin
            idx_d = idx_wrap[IdxW-1:0];
            if (lit_q && (elapsed_inc < cur_dly_q)) begin
              // step still running
              elapsed_d = elapsed_inc;
            end else begin
              // drop the current relay (if any) and light the next step
              if (lit_q) begin
                relay_d = relay_q & ~relay_mask(cur_ch_q);
                idx_d   = idx_next[IdxW-1:0];
              end
              relay_d   = relay_d | relay_mask(step_ch_q[rd_idx]);
              cur_ch_d  = step_ch_q[rd_idx];
              cur_dly_d = step_dly_q[rd_idx];
              elapsed_d = '0;
              lit_d     = 1'b1;
            end
          end
        end
        FUNC_DEACT: begin
          active_d  = 1'b0;
          cycle_d   = 1'b0;
          loading_d = 1'b0;
          relay_d   = '0;
        end
        FUNC_SINGLE: begin
          relay_d   = relay_q | relay_mask(cmd_i.channel);
          active_d  = 1'b1;
          cycle_d   = 1'b0;
          loading_d = 1'b0;
        end
        FUNC_ENTRY: begin
          // first entry of a run clears the list; extras are dropped
          loading_d = 1'b1;
          count_d   = cnt_eff;
          if (32'(cnt_eff) < MaxSteps) begin
            wr_en   = 1'b1;
            count_d = cnt_eff + CntW'(1);
          end
        end
        FUNC_START: begin
          idx_d     = '0;
          elapsed_d = '0;
          lit_d     = 1'b0;
          cycle_d   = 1'b1;
          active_d  = 1'b1;
          loading_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result after this command
  always_comb begin
    step_ext               = (IdxW + StepW)'(idx_d);
    result_o.relay_on      = relay_d;
    result_o.alarm_active  = active_d;
    result_o.cycle_running = cycle_d;
    result_o.current_step  = step_ext[StepW-1:0];
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q   <= '0;
      active_q  <= 1'b0;
      cycle_q   <= 1'b0;
      loading_q <= 1'b0;
      lit_q     <= 1'b0;
      count_q   <= '0;
      idx_q     <= '0;
      elapsed_q <= '0;
    end else begin
      relay_q   <= relay_d;
      active_q  <= active_d;
      cycle_q   <= cycle_d;
      loading_q <= loading_d;
      lit_q     <= lit_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Lit-step copy and register file, no reset
  always_ff @(posedge clk_i) begin
    cur_ch_q  <= cur_ch_d;
    cur_dly_q <= cur_dly_d;
    if (wr_en) begin
      step_ch_q[wr_idx]  <= cmd_i.channel;
      step_dly_q[wr_idx] <= cmd_i.delay_ticks;
    end
  end

`ifndef SYNTHESIS
  // cycling always implies an active alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni) cycle_q |-> active_q)
    else $error("cycle running without active alarm");

  // list never holds more than the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= MaxSteps)
    else $error("step count beyond table depth");

  // lit-step copy matches the table while the cycle is live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (lit_q && cycle_q && !loading_q) |->
      (cur_ch_q == step_ch_q[idx_q] && cur_dly_q == step_dly_q[idx_q]))
    else $error("lit-step copy out of sync with step table");
`endif

endmodule

`default_nettype wire

// ===== rtl/timed_relay_sequencer.sv =====
// Top level of the timed relay sequencer: handshakes and result register.
`default_nettype none

// Timed relay sequencer. Each accepted command (tick, deactivate, activate single,
// sequence entry, start cycle) produces exactly one result transaction carrying the
// relay bits, alarm and cycle flags and the lit step index after that command.
// The core's next-state logic evaluates each command in the cycle it is accepted,
// and the result is captured in a single output register, so the result appears in
// the cycle after acceptance. The output register is refilled in the same cycle it is
// drained, giving one command per clock as long as the result side keeps taking
// transactions; in_ready_o drops only while a result waits and out_ready_i is low.
// No clearing pass is needed after reset.
module timed_relay_sequencer
  import trs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire trs_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output trs_out_t      out_data_o
);

  logic     in_fire;
  logic     out_valid_q, out_valid_d;
  trs_out_t out_data_q;
  trs_out_t result;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  trs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_en_i (in_fire),
    .cmd_i    (in_data_i),
    .result_o (result)
  );

  // Result register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on each accepted command
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // an accepted command always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> out_valid_o)
    else $error("accepted command produced no result");

  // deactivate leaves every relay off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_fire && in_data_i.func == FUNC_DEACT) |=>
      (out_data_o.relay_on == '0 && !out_data_o.alarm_active))
    else $error("deactivate left a relay on");

  // an empty result register never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
